// File: rtl/fbsm_pkg.sv
// Shared definitions for the frame buffer slot manager.
// Holds parameter defaults, action, status and slot-state codes and the slot entry type.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package fbsm_pkg;

	localparam int SLOTS_DEFAULT     = 32;
	localparam int MIN_SLOTS_DEFAULT = 2;

	// action codes
	localparam logic [2:0] ACT_DEQUEUE   = 3'd0;
	localparam logic [2:0] ACT_QUEUE     = 3'd1;
	localparam logic [2:0] ACT_CANCEL    = 3'd2;
	localparam logic [2:0] ACT_ACQUIRE   = 3'd3;
	localparam logic [2:0] ACT_RELEASE   = 3'd4;
	localparam logic [2:0] ACT_SET_COUNT = 3'd5;
	localparam logic [2:0] ACT_ABANDON   = 3'd6;

	// status codes
	localparam logic [2:0] STATUS_OK        = 3'd0;
	localparam logic [2:0] STATUS_BAD_COUNT = 3'd1;
	localparam logic [2:0] STATUS_INVALID   = 3'd2;
	localparam logic [2:0] STATUS_NONE      = 3'd3;
	localparam logic [2:0] STATUS_STALE     = 3'd4;

	// slot states
	localparam logic [1:0] SLOT_FREE      = 2'd0;
	localparam logic [1:0] SLOT_DEQUEUED  = 2'd1;
	localparam logic [1:0] SLOT_QUEUED    = 2'd2;
	localparam logic [1:0] SLOT_RENDERING = 2'd3;

	typedef struct packed {
		logic [1:0]  st;
		logic        alloc;
		logic [31:0] frame;
	} entry_t;

endpackage
`default_nettype wire

// File: rtl/frame_buffer_slot_manager.sv
// Frame buffer slot manager: slot table in one synchronous memory, scanned by a sequencer.
// Depends on fbsm_pkg.
//
// Single-slot actions go from DECODE straight to OUT; dequeue, acquire and a valid set_count
// that changes the count scan the active slots in SCAN, one memory read per cycle, before OUT.
// One item is handled at a time; the next item is taken once the result is in the output
// register. Reset clears control state and the per-slot valid bits, so every slot reads free,
// unallocated, frame 0 right after reset, without a clearing pass.
`timescale 1ns / 1ps
`default_nettype none
module frame_buffer_slot_manager #(
	parameter int SLOTS     = fbsm_pkg::SLOTS_DEFAULT,
	parameter int MIN_SLOTS = fbsm_pkg::MIN_SLOTS_DEFAULT
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [31:0] s_tdata,  // action[2:0], slot[7:3], count[13:8], generation_in[29:14]
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [31:0] m_tdata   // status[2:0], slot_out[7:3], needs_alloc[8], generation_out[24:9]
);
	import fbsm_pkg::*;

	localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int CW = $clog2(SLOTS + 1);
	localparam int XW = (CW > 6) ? CW : 6;

	localparam logic [1:0] S_IDLE   = 2'd0;
	localparam logic [1:0] S_DECODE = 2'd1;
	localparam logic [1:0] S_SCAN   = 2'd2;
	localparam logic [1:0] S_OUT    = 2'd3;

	logic [1:0]  state_q;
	logic [2:0]  act_q;
	logic [4:0]  slot_q;
	logic [5:0]  cnt_q;
	logic [15:0] gin_q;

	logic [CW-1:0] active_q;
	logic [31:0]   frame_count_q;
	logic [15:0]   generation_q;

	// slot table
	entry_t        mem [SLOTS];
	logic [SLOTS-1:0] valid_q;
	entry_t        rd_data_q;
	logic          rd_valid_q;
	entry_t        entry;
	logic [IW-1:0] rd_addr;
	logic [63:0]   s_ext;

	logic          wr_en_q;
	logic [IW-1:0] wr_addr_q;
	entry_t        wr_data_q;
	logic          clear_all_q;

	// scan sequencer
	logic [CW-1:0] idx_q;
	logic          rd_vld_s1;
	logic [IW-1:0] rd_idx_s1;
	logic          found_q;
	logic          busy_q;
	logic [IW-1:0] best_idx_q;
	entry_t        best_q;
	logic [1:0]    want;
	logic          issue;

	// result held until the output register frees up
	logic [2:0]  res_status_q;
	logic [4:0]  res_slot_q;
	logic        res_alloc_q;
	logic [15:0] res_gen_q;

	logic          m_tvalid_q;
	logic [2:0]    out_status_q;
	logic [4:0]    out_slot_q;
	logic          out_alloc_q;
	logic [15:0]   out_gen_q;

	logic [XW-1:0] cnt_x;
	logic [XW-1:0] active_x;
	logic [XW-1:0] slot_x;
	logic          slot_in_range;
	logic [63:0]   best_ext;

	assign s_tready = (state_q == S_IDLE);
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {7'd0, out_gen_q, out_alloc_q, out_slot_q, out_status_q};

	assign s_ext   = 64'(s_tdata[7:3]);
	assign rd_addr = (state_q == S_IDLE) ? s_ext[IW-1:0] : idx_q[IW-1:0];
	assign entry   = rd_valid_q ? rd_data_q : '0;

	assign cnt_x         = XW'(cnt_q);
	assign active_x      = XW'(active_q);
	assign slot_x        = XW'(slot_q);
	assign slot_in_range = slot_x < active_x;
	assign issue         = idx_q < active_q;
	assign want          = (act_q == ACT_ACQUIRE) ? SLOT_QUEUED : SLOT_FREE;
	assign best_ext      = 64'(best_idx_q);

	// memory: one read and one write port, read data registered
	always_ff @(posedge clk) begin
		if (wr_en_q) begin
			mem[wr_addr_q] <= wr_data_q;
		end
		rd_data_q <= mem[rd_addr];
	end

	// an entry that is not valid reads as a free, unallocated slot with frame 0
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q    <= '0;
			rd_valid_q <= 1'b0;
		end else begin
			rd_valid_q <= valid_q[rd_addr];
			if (clear_all_q) begin
				valid_q <= '0;
			end else if (wr_en_q) begin
				valid_q[wr_addr_q] <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			active_q      <= CW'(MIN_SLOTS);
			frame_count_q <= '0;
			generation_q  <= '0;
			wr_en_q       <= 1'b0;
			clear_all_q   <= 1'b0;
			rd_vld_s1     <= 1'b0;
			m_tvalid_q    <= 1'b0;
		end else begin
			wr_en_q     <= 1'b0;
			clear_all_q <= 1'b0;
			if (m_tvalid_q && m_tready) begin
				m_tvalid_q <= 1'b0;
			end

			unique case (state_q)
				S_IDLE: begin
					if (s_tvalid) begin
						act_q   <= s_tdata[2:0];
						slot_q  <= s_tdata[7:3];
						cnt_q   <= s_tdata[13:8];
						gin_q   <= s_tdata[29:14];
						state_q <= S_DECODE;
					end
				end

				S_DECODE: begin
					res_status_q <= STATUS_OK;
					res_slot_q   <= '0;
					res_alloc_q  <= 1'b0;
					res_gen_q    <= '0;
					state_q      <= S_OUT;
					wr_addr_q    <= slot_x[IW-1:0];
					idx_q        <= '0;
					rd_vld_s1    <= 1'b0;
					found_q      <= 1'b0;
					busy_q       <= 1'b0;
					unique case (act_q)
						ACT_DEQUEUE, ACT_ACQUIRE: begin
							state_q <= S_SCAN;
						end
						ACT_QUEUE: begin
							if (!slot_in_range || entry.st != SLOT_DEQUEUED) begin
								res_status_q <= STATUS_INVALID;
							end else begin
								frame_count_q <= frame_count_q + 32'd1;
								wr_en_q       <= 1'b1;
								wr_data_q     <= '{st: SLOT_QUEUED, alloc: entry.alloc,
									frame: frame_count_q + 32'd1};
							end
						end
						ACT_CANCEL: begin
							if (!slot_in_range || entry.st != SLOT_DEQUEUED) begin
								res_status_q <= STATUS_INVALID;
							end else begin
								wr_en_q   <= 1'b1;
								wr_data_q <= '{st: SLOT_FREE, alloc: entry.alloc, frame: 32'd0};
							end
						end
						ACT_RELEASE: begin
							// generation is checked before the slot
							if (gin_q != generation_q) begin
								res_status_q <= STATUS_STALE;
							end else if (!slot_in_range || entry.st != SLOT_RENDERING) begin
								res_status_q <= STATUS_INVALID;
							end else begin
								wr_en_q   <= 1'b1;
								wr_data_q <= '{st: SLOT_FREE, alloc: entry.alloc,
									frame: entry.frame};
							end
						end
						ACT_SET_COUNT: begin
							if (cnt_x > XW'(SLOTS)) begin
								res_status_q <= STATUS_BAD_COUNT;
							end else if (cnt_x == active_x) begin
								res_status_q <= STATUS_OK;
							end else if (cnt_x < XW'(MIN_SLOTS)) begin
								res_status_q <= STATUS_BAD_COUNT;
							end else begin
								state_q <= S_SCAN;
							end
						end
						ACT_ABANDON: begin
							generation_q <= generation_q + 16'd1;
							clear_all_q  <= 1'b1;
						end
						default: begin
							res_status_q <= STATUS_INVALID;
						end
					endcase
				end

				S_SCAN: begin
					rd_vld_s1 <= issue;
					rd_idx_s1 <= idx_q[IW-1:0];
					if (issue) begin
						idx_q <= idx_q + CW'(1);
					end
					if (rd_vld_s1) begin
						if (entry.st == SLOT_DEQUEUED || entry.st == SLOT_RENDERING) begin
							busy_q <= 1'b1;
						end
						// strict compare keeps the lowest index on ties
						if (entry.st == want && (!found_q || entry.frame < best_q.frame)) begin
							found_q    <= 1'b1;
							best_idx_q <= rd_idx_s1;
							best_q     <= entry;
						end
					end else if (!issue) begin
						state_q   <= S_OUT;
						wr_addr_q <= best_idx_q;
						if (act_q == ACT_SET_COUNT) begin
							if (busy_q) begin
								res_status_q <= STATUS_INVALID;
							end else begin
								if (cnt_x < active_x) begin
									clear_all_q <= 1'b1;
								end
								active_q <= CW'(cnt_x);
							end
						end else if (!found_q) begin
							res_status_q <= STATUS_NONE;
						end else if (act_q == ACT_DEQUEUE) begin
							res_slot_q  <= best_ext[4:0];
							res_alloc_q <= !best_q.alloc;
							wr_en_q     <= 1'b1;
							wr_data_q   <= '{st: SLOT_DEQUEUED, alloc: 1'b1, frame: best_q.frame};
						end else begin
							res_slot_q <= best_ext[4:0];
							res_gen_q  <= generation_q;
							wr_en_q    <= 1'b1;
							wr_data_q  <= '{st: SLOT_RENDERING, alloc: best_q.alloc,
								frame: best_q.frame};
						end
					end
				end

				S_OUT: begin
					// hold the result until the output register is free
					if (!m_tvalid_q || m_tready) begin
						m_tvalid_q   <= 1'b1;
						out_status_q <= res_status_q;
						out_slot_q   <= res_slot_q;
						out_alloc_q  <= res_alloc_q;
						out_gen_q    <= res_gen_q;
						state_q      <= S_IDLE;
					end
				end
			endcase
		end
	end

endmodule
`default_nettype wire
